>>> rtl/core/stream_pattern_deleter_defines.svh
// Assertion macros shared by the stream pattern deleter RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef STREAM_PATTERN_DELETER_DEFINES_SVH
`define STREAM_PATTERN_DELETER_DEFINES_SVH

// same-cycle implication
`define SPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/spd_pkg.sv
// Package for the stream pattern deleter: widths, register indexes and the
// control and compare structs passed between the top level and its cells.
`timescale 1ns / 1ps

package spd_pkg;

  localparam int unsigned PatternMaxDef = 8;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned PatBytesW     = 64;
  localparam int unsigned CfgIdxW       = 1;

  localparam logic [CfgIdxW-1:0] CfgPatternLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPatternBytes  = 1'b1;

  localparam logic [ByteW-1:0] NulByte = 8'h00;

  typedef struct packed {
    logic load;
    logic shift;
  } spd_cell_ctrl_t;

  typedef struct packed {
    logic cur;
    logic prev;
  } spd_cell_hit_t;

endpackage

>>> rtl/core/spd_cell.sv
// One held-byte cell of the stream pattern deleter chain.
// Depends on spd_pkg for widths and the control and compare structs.
`timescale 1ns / 1ps

module spd_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spd_pkg::spd_cell_ctrl_t     ctrl_i,
  input  logic [spd_pkg::ByteW-1:0]   new_byte_i,
  input  logic [spd_pkg::ByteW-1:0]   nbr_byte_i,
  input  logic [spd_pkg::ByteW-1:0]   pat_cur_i,
  input  logic [spd_pkg::ByteW-1:0]   pat_prev_i,
  output logic [spd_pkg::ByteW-1:0]   byte_o,
  output spd_pkg::spd_cell_hit_t      hit_o
);

  logic [spd_pkg::ByteW-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = nbr_byte_i;
    end else if (ctrl_i.load) begin
      byte_d = new_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= spd_pkg::NulByte;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o     = byte_q;
  assign hit_o.cur  = (byte_q == pat_cur_i);
  assign hit_o.prev = (byte_q == pat_prev_i);

endmodule

>>> rtl/core/stream_pattern_deleter.sv
// Stream pattern deleter top level: control sequencer, output register and
// the chain of held-byte cells. Depends on spd_pkg, spd_cell and the defines.
//
// Usage:
//   s_axis carries one text byte per beat (tdata) with tlast on the final
//   byte. m_axis returns surviving bytes in order (tdata), tuser set on a
//   beat that carries no byte and only ends the text, tlast on the final
//   beat of a text. The cfg channel writes pattern_length (index 0) and
//   pattern_bytes (index 1); cfg_ready_o is always high. Write it idle only.
// Timing:
//   A byte enters the chain in idle only; the scan gives out one byte per cycle
//   while the output slot is free, makes a closing decision and, on a final
//   byte still holding a match, takes a further step for the flush or end beat.
//   Output beats leave through a register in the cycle after each decision.
// Reset:
//   Clears held count, state and output valid; pattern_length resets to 1
//   and pattern_bytes to zero.
// Stall:
//   While m_axis_tready is low the result waits in the output register and
//   the chain holds; the next byte can still be taken if nothing is pending.
`timescale 1ns / 1ps
`include "stream_pattern_deleter_defines.svh"

module stream_pattern_deleter #(
  parameter int unsigned PatternMax = spd_pkg::PatternMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [spd_pkg::PatBytesW-1:0]  cfg_data_i,
  // text in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [spd_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tlast,   // text_last
  // kept bytes out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [spd_pkg::ByteW-1:0]      m_axis_tdata,   // [7:0] kept_byte
  output logic                           m_axis_tuser,   // [0] end_empty
  output logic                           m_axis_tlast    // out_last
);

  localparam int unsigned CntW = $clog2(PatternMax + 1);
  localparam int unsigned LenW = spd_pkg::LenW;
  localparam int unsigned ByteW = spd_pkg::ByteW;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic last_q, last_d;
  logic flush_q, flush_d;
  logic emitted_q, emitted_d;
  logic [LenW-1:0] len_q;
  logic [spd_pkg::PatBytesW-1:0] pat_q;

  logic out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic out_empty_q, out_empty_d;
  logic out_last_q, out_last_d;

  logic [LenW-1:0] act_len;
  logic [LenW-1:0] cnt_len;
  logic in_fire, slot_free, shift_en;
  logic prefix, sprefix;

  logic [PatternMax-1:0] cell_valid;
  logic [ByteW-1:0] cell_byte [PatternMax];
  spd_pkg::spd_cell_hit_t cell_hit [PatternMax];
  spd_pkg::spd_cell_ctrl_t cell_ctrl [PatternMax];

  // ---------------------------------------------------------------------------
  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenW'(1);
      pat_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spd_pkg::CfgPatternLength: len_q <= cfg_data_i[LenW-1:0];
        spd_pkg::CfgPatternBytes:  pat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (len_q == '0) begin
      act_len = LenW'(1);
    end else if (len_q > LenW'(PatternMax)) begin
      act_len = LenW'(PatternMax);
    end else begin
      act_len = len_q;
    end
  end

  // ---------------------------------------------------------------------------
  // cell chain
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    logic [ByteW-1:0] nbr_byte;
    logic [ByteW-1:0] pat_prev;

    if (i == PatternMax - 1) begin : g_tail
      assign nbr_byte = spd_pkg::NulByte;
    end else begin : g_mid
      assign nbr_byte = cell_byte[i+1];
    end

    if (i == 0) begin : g_head
      assign pat_prev = spd_pkg::NulByte;
    end else begin : g_body
      assign pat_prev = pat_q[ByteW*(i-1) +: ByteW];
    end

    assign cell_valid[i]      = (CntW'(i) < cnt_q);
    assign cell_ctrl[i].load  = in_fire && (cnt_q == CntW'(i));
    assign cell_ctrl[i].shift = shift_en;

    spd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl[i]),
      .new_byte_i (s_axis_tdata),
      .nbr_byte_i (nbr_byte),
      .pat_cur_i  (pat_q[ByteW*i +: ByteW]),
      .pat_prev_i (pat_prev),
      .byte_o     (cell_byte[i]),
      .hit_o      (cell_hit[i])
    );
  end

  assign cnt_len = LenW'(cnt_q);

  // prefix of the held bytes, and of the held bytes after one shift
  always_comb begin
    logic all_cur, all_prev;
    all_cur  = 1'b1;
    all_prev = 1'b1;
    for (int i = 0; i < PatternMax; i++) begin
      if (cell_valid[i] && !cell_hit[i].cur) begin
        all_cur = 1'b0;
      end
      if ((i != 0) && cell_valid[i] && !cell_hit[i].prev) begin
        all_prev = 1'b0;
      end
    end
    prefix  = all_cur && (cnt_len <= act_len);
    sprefix = all_prev && ((cnt_len - LenW'(1)) <= act_len);
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    last_d      = last_q;
    flush_d     = flush_q;
    emitted_d   = emitted_q;
    shift_en    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_empty_d = out_empty_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (cnt_q < CntW'(PatternMax)) begin
            cnt_d = cnt_q + CntW'(1);
          end
          last_d    = s_axis_tlast;
          flush_d   = 1'b0;
          emitted_d = 1'b0;
          state_d   = StScan;
        end
      end
      StScan: begin
        priority if (cnt_q == '0) begin
          if (last_q && !emitted_q) begin
            if (slot_free) begin
              out_valid_d = 1'b1;
              out_byte_d  = spd_pkg::NulByte;
              out_empty_d = 1'b1;
              out_last_d  = 1'b1;
              emitted_d   = 1'b1;
              state_d     = StIdle;
            end
          end else begin
            state_d = StIdle;
          end
        end else if (prefix && !flush_q) begin
          if (cnt_len == act_len) begin
            cnt_d = '0;
            if (!last_q) begin
              state_d = StIdle;
            end
          end else if (last_q) begin
            flush_d = 1'b1;
          end else begin
            state_d = StIdle;
          end
        end else begin
          // drop the front byte to the output and advance the chain
          if (slot_free) begin
            shift_en    = 1'b1;
            cnt_d       = cnt_q - CntW'(1);
            emitted_d   = 1'b1;
            out_valid_d = 1'b1;
            out_byte_d  = cell_byte[0];
            out_empty_d = 1'b0;
            out_last_d  = last_q && ((cnt_q == CntW'(1)) ||
                          (!flush_q && sprefix && ((cnt_len - LenW'(1)) == act_len)));
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      flush_q     <= 1'b0;
      emitted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      flush_q     <= flush_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    out_empty_q <= out_empty_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tuser  = out_empty_q;
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  `SPD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CntW'(PatternMax), "held count overflow")
  `SPD_ASSERT_IMP(a_flush_last, flush_q, last_q, "flush outside a final byte")
  `SPD_ASSERT_IMP(a_empty_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
                  "empty beat without tlast")
  `SPD_ASSERT_NXT(a_end_clear, (state_q == StScan) && (state_d == StIdle) && last_q,
                  cnt_q == '0, "held bytes left after end of text")

endmodule

>>> verif/tb.sv
// Self-checking bench for stream_pattern_deleter: directed and random texts with
// random stalls on both streams, kept bytes checked against an in-bench predictor.
// Depends on spd_pkg and the stream_pattern_deleter RTL.
`timescale 1ns / 1ps

module tb;
  import spd_pkg::*;

  localparam int unsigned PatternMax  = PatternMaxDef;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned RandomItems = 325;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             is_last;
  } text_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] kept;
    logic             empty;
    logic             is_last;
  } kept_beat_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = CfgPatternLength;
  logic [PatBytesW-1:0] cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [ByteW-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  stream_pattern_deleter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predictor state
  logic [ByteW-1:0]     held_buf [PatternMax];
  int unsigned          held_num = 0;
  logic [LenW-1:0]      pat_len_reg = 4'd1;
  logic [PatBytesW-1:0] pat_bytes_reg = '0;

  text_beat_t  text_q [$];
  kept_beat_t  kept_due_q [$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;

  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold_total = 0;
  int unsigned rx_held = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned active_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > PatternMax) return PatternMax;
    return pat_len_reg;
  endfunction

  function automatic void give_out_front();
    kept_beat_t r;
    r.kept    = held_buf[0];
    r.empty   = 1'b0;
    r.is_last = 1'b0;
    kept_due_q.push_back(r);
    for (int i = 1; i < held_num; i++) held_buf[i-1] = held_buf[i];
    held_num--;
  endfunction

  function automatic void predict_kept(input logic [ByteW-1:0] ch, input logic is_last);
    int unsigned plen;
    int unsigned n_out;
    bit          is_prefix;
    bit          settled;
    kept_beat_t  tail;
    plen    = active_len();
    n_out   = 0;
    settled = 1'b0;
    if (held_num < PatternMax) begin
      held_buf[held_num] = ch;
      held_num++;
    end
    while (held_num > 0 && !settled) begin
      is_prefix = (held_num <= plen);
      for (int i = 0; i < held_num; i++) begin
        if (held_buf[i] != pat_bytes_reg[8*i +: 8]) is_prefix = 1'b0;
      end
      if (is_prefix) begin
        if (held_num == plen) held_num = 0;
        settled = 1'b1;
      end else begin
        give_out_front();
        n_out++;
      end
    end
    if (is_last) begin
      while (held_num > 0 && n_out < PatternMax) begin
        give_out_front();
        n_out++;
      end
      held_num = 0;
      if (n_out == 0) begin
        tail.kept    = NulByte;
        tail.empty   = 1'b1;
        tail.is_last = 1'b1;
      end else begin
        tail = kept_due_q.pop_back();
        tail.is_last = 1'b1;
      end
      kept_due_q.push_back(tail);
    end
  endfunction

  // text driver
  always @(negedge clk_i) begin
    text_beat_t beat;
    if (!s_axis_tvalid || in_taken) begin
      if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        beat = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat.ch;
        s_axis_tlast  <= beat.is_last;
        tx_wait = tx_idle_en ? $urandom_range(0, 10) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // kept-byte receiver
  always @(negedge clk_i) begin
    if (rx_held < rx_hold_total) begin
      rx_held++;
      m_axis_tready <= 1'b0;
    end else begin
      if (out_taken) rx_wait = rx_idle_en ? $urandom_range(0, 10) : 0;
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    kept_beat_t want;
    kept_beat_t got;
    in_taken  <= s_axis_tvalid && s_axis_tready;
    out_taken <= m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_kept(s_axis_tdata, s_axis_tlast);
        n_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kept    = m_axis_tdata;
        got.empty   = m_axis_tuser;
        got.is_last = m_axis_tlast;
        if (kept_due_q.size() == 0) begin
          $display("%0t: unexpected beat byte %h empty %b last %b", $time,
                   got.kept, got.empty, got.is_last);
          n_errors++;
        end else begin
          want = kept_due_q.pop_front();
          if (got !== want) begin
            $display("%0t: expected byte %h empty %b last %b, got byte %h empty %b last %b",
                     $time, want.kept, want.empty, want.is_last,
                     got.kept, got.empty, got.is_last);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic push_beat(input logic [ByteW-1:0] ch, input logic is_last);
    text_beat_t beat;
    beat.ch      = ch;
    beat.is_last = is_last;
    text_q.push_back(beat);
    n_queued++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PatBytesW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgPatternLength) pat_len_reg = val[LenW-1:0];
    else pat_bytes_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (!(n_accepted == n_queued && kept_due_q.size() == 0)) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random_text(input bit close_it, input int unsigned max_len);
    logic [ByteW-1:0] bytes_q [$];
    logic [ByteW-1:0] alpha [3];
    int unsigned      plen;
    int unsigned      k;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      want_len;
    plen = active_len();
    for (k = 0; k < 3; k++) begin
      n = $urandom_range(0, plen - 1);
      alpha[k] = pat_bytes_reg[8*n +: 8];
    end
    want_len = $urandom_range(1, max_len);
    while (bytes_q.size() < want_len) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        for (k = 0; k < plen; k++) bytes_q.push_back(pat_bytes_reg[8*k +: 8]);
      end else if (pick < 6) begin
        n = $urandom_range(1, plen);
        for (k = 0; k < n; k++) bytes_q.push_back(pat_bytes_reg[8*k +: 8]);
      end else if (pick < 8) begin
        bytes_q.push_back(alpha[$urandom_range(0, 2)]);
      end else begin
        bytes_q.push_back(ByteW'($urandom_range(0, 255)));
      end
    end
    foreach (bytes_q[i]) push_beat(bytes_q[i], close_it && (i == bytes_q.size() - 1));
  endtask

  task automatic configure_random();
    logic [ByteW-1:0]     alpha [3];
    logic [PatBytesW-1:0] pat;
    logic [LenW-1:0]      len;
    int unsigned          alpha_n;
    alpha_n = $urandom_range(1, 3);
    for (int i = 0; i < 3; i++) alpha[i] = ByteW'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      pat = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = alpha[$urandom_range(0, alpha_n - 1)];
    end
    len = ($urandom_range(0, 7) == 0) ? LenW'($urandom_range(0, 15))
                                      : LenW'($urandom_range(1, 8));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgPatternLength, {60'd0, len});
      write_reg(CfgPatternBytes, pat);
    end else begin
      write_reg(CfgPatternBytes, pat);
      write_reg(CfgPatternLength, {60'd0, len});
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    int unsigned target;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset pattern: one zero byte
    push_beat(8'h00, 1'b1);
    push_beat(8'hFF, 1'b1);
    wait_idle();

    // length zero acts as one
    write_reg(CfgPatternLength, 64'd0);
    write_reg(CfgPatternBytes, 64'h0000_0000_0000_005A);
    push_beat(8'h5A, 1'b0);
    push_beat(8'h5A, 1'b0);
    push_beat(8'h01, 1'b1);
    wait_idle();

    // fall back after a partial match
    write_reg(CfgPatternLength, 64'd3);
    write_reg(CfgPatternBytes, 64'h0000_0000_0063_6261);
    push_beat(8'h61, 1'b0);
    push_beat(8'h61, 1'b0);
    push_beat(8'h62, 1'b0);
    push_beat(8'h63, 1'b0);
    push_beat(8'h78, 1'b1);
    // change the length while bytes are held
    push_beat(8'h61, 1'b0);
    push_beat(8'h62, 1'b0);
    wait_idle();
    write_reg(CfgPatternLength, 64'd1);
    push_beat(8'h63, 1'b1);
    wait_idle();

    // length above range acts as the maximum
    write_reg(CfgPatternLength, 64'd15);
    write_reg(CfgPatternBytes, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++) push_beat(8'hFF, i == 7);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h7F, 1'b1);
    wait_idle();

    phase = 0;
    while (n_queued < RandomItems) begin
      configure_random();
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        tx_idle_en = 1'b0;
        rx_hold_total = rx_hold_total + 300;
      end
      start  = n_queued;
      target = $urandom_range(20, 60);
      while (n_queued - start < target) queue_random_text(1'b1, 14);
      if ($urandom_range(0, 2) == 0) queue_random_text(1'b0, 4);
      wait_idle();
      phase++;
    end

    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
